// ----- hw/rtl/msd_pkg.sv -----
// Shared types, codes and constants of the MQTT stream deframer.
package msd_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
    localparam int unsigned TOPIC_CAPACITY = 64;
    localparam logic [27:0] MAX_LEN_RESET = 28'd1024;

    localparam logic [3:0] TYPE_PUBLISH = 4'h3;
    localparam logic [3:0] TYPE_RSVD_LO = 4'h0;
    localparam logic [3:0] TYPE_RSVD_HI = 4'hF;

    localparam logic [1:0] KIND_TOPIC   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_BAD_TYPE      = 3'd1;
    localparam logic [2:0] ST_LENGTH        = 3'd2;
    localparam logic [2:0] ST_TOPIC_LONG    = 3'd3;
    localparam logic [2:0] ST_TOPIC_OVERRUN = 3'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_end;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  data_byte;
        logic [3:0]  packet_type;
        logic [1:0]  qos_level;
        logic [27:0] remaining_length;
        logic        last_of_packet;
        logic [2:0]  status;
    } out_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- hw/rtl/msd_front.sv -----
// Front end: header, length, topic and payload parsing, one byte per cycle while accept is high.
module msd_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  msd_pkg::in_word_t  in_word,
    input  logic [27:0]        max_len,
    output logic               res_valid,
    output msd_pkg::out_word_t res_word
);

    typedef enum logic [6:0] {
        PH_HEADER   = 7'b0000001,
        PH_LENGTH   = 7'b0000010,
        PH_TOPIC_HI = 7'b0000100,
        PH_TOPIC_LO = 7'b0001000,
        PH_TOPIC    = 7'b0010000,
        PH_PAYLOAD  = 7'b0100000,
        PH_DROP     = 7'b1000000
    } phase_t;

    localparam logic [16:0] TOPIC_CAP = 17'(msd_pkg::TOPIC_CAPACITY);

    phase_t      phase_reg, phase_next;
    logic [27:0] acc_reg, acc_next;
    logic [1:0]  lcount_reg, lcount_next;
    logic [27:0] left_reg, left_next;
    logic [7:0]  topic_hi_reg, topic_hi_next;
    logic [15:0] tleft_reg, tleft_next;
    logic [3:0]  type_reg, type_next;
    logic [1:0]  qos_reg, qos_next;
    logic [2:0]  pend_reg, pend_next;

    logic [7:0]  b;
    logic        endb;
    logic [27:0] acc_new;
    logic [15:0] topic_size;
    logic [15:0] tleft_dec;
    logic        pkt_end;
    logic        has_data;
    logic [1:0]  data_kind;
    logic [1:0]  r_kind;
    logic [7:0]  r_data;
    logic        r_last;
    logic [2:0]  r_status;

    assign b    = in_word.rx_byte;
    assign endb = in_word.buffer_end;
    assign topic_size = {topic_hi_reg, b};
    assign tleft_dec = tleft_reg - 16'd1;
    assign pkt_end   = (left_reg == 28'd1);

    always_comb begin
        case (lcount_reg)
            2'd0:    acc_new = acc_reg | {21'd0, b[6:0]};
            2'd1:    acc_new = acc_reg | {14'd0, b[6:0], 7'd0};
            2'd2:    acc_new = acc_reg | {7'd0, b[6:0], 14'd0};
            default: acc_new = acc_reg | {b[6:0], 21'd0};
        endcase
    end

    always_comb begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        lcount_next   = lcount_reg;
        left_next     = left_reg;
        topic_hi_next = topic_hi_reg;
        tleft_next    = tleft_reg;
        type_next     = type_reg;
        qos_next      = qos_reg;
        pend_next     = pend_reg;
        has_data      = 1'b0;
        data_kind     = msd_pkg::KIND_PAYLOAD;
        res_valid     = 1'b0;
        r_kind        = msd_pkg::KIND_STATUS;
        r_data        = 8'd0;
        r_last        = 1'b0;
        r_status      = msd_pkg::ST_OK;

        case (phase_reg)
            PH_HEADER: begin
                type_next     = b[7:4];
                qos_next      = b[2:1];
                pend_next     = msd_pkg::ST_OK;
                acc_next      = 28'd0;
                lcount_next   = 2'd0;
                left_next     = 28'd0;
                topic_hi_next = 8'd0;
                tleft_next    = 16'd0;
                if (b[7:4] == msd_pkg::TYPE_RSVD_LO || b[7:4] == msd_pkg::TYPE_RSVD_HI) begin
                    res_valid = 1'b1;
                    r_last    = 1'b1;
                    r_status  = msd_pkg::ST_BAD_TYPE;
                end else if (endb) begin
                    res_valid = 1'b1;
                    r_last    = 1'b1;
                    r_status  = msd_pkg::ST_LENGTH;
                end else begin
                    phase_next = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                acc_next = acc_new;
                if (b[7]) begin
                    if (lcount_reg == 2'd3) begin
                        res_valid = 1'b1;
                        r_last    = 1'b1;
                        r_status  = msd_pkg::ST_LENGTH;
                    end else begin
                        lcount_next = lcount_reg + 2'd1;
                        if (endb) begin
                            res_valid = 1'b1;
                            r_last    = 1'b1;
                            r_status  = msd_pkg::ST_LENGTH;
                        end
                    end
                end else if (acc_new > max_len) begin
                    res_valid = 1'b1;
                    r_last    = 1'b1;
                    r_status  = msd_pkg::ST_LENGTH;
                end else begin
                    left_next = acc_new;
                    if (acc_new == 28'd0) begin
                        res_valid = 1'b1;
                        r_last    = 1'b1;
                        if (type_reg == msd_pkg::TYPE_PUBLISH) begin
                            r_status = msd_pkg::ST_TOPIC_OVERRUN;
                        end else begin
                            phase_next = PH_HEADER;
                        end
                    end else if (endb) begin
                        res_valid = 1'b1;
                        r_last    = 1'b1;
                        r_status  = msd_pkg::ST_LENGTH;
                    end else if (type_reg == msd_pkg::TYPE_PUBLISH) begin
                        phase_next = PH_TOPIC_HI;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_TOPIC_HI, PH_TOPIC_LO, PH_TOPIC, PH_PAYLOAD: begin
                left_next = left_reg - 28'd1;
                if (phase_reg == PH_TOPIC_HI) begin
                    topic_hi_next = b;
                    phase_next    = PH_TOPIC_LO;
                    if (pkt_end && pend_reg == msd_pkg::ST_OK) begin
                        pend_next = msd_pkg::ST_TOPIC_OVERRUN;
                    end
                end else if (phase_reg == PH_TOPIC_LO) begin
                    tleft_next = topic_size;
                    phase_next = (topic_size != 16'd0) ? PH_TOPIC : PH_PAYLOAD;
                    if ({1'b0, topic_size} + 17'd1 >= TOPIC_CAP) begin
                        pend_next = msd_pkg::ST_TOPIC_LONG;
                    end else if ({12'd0, topic_size} + 28'd2 > acc_reg) begin
                        pend_next = msd_pkg::ST_TOPIC_OVERRUN;
                    end
                end else if (phase_reg == PH_TOPIC) begin
                    has_data   = 1'b1;
                    data_kind  = msd_pkg::KIND_TOPIC;
                    tleft_next = tleft_dec;
                    if (tleft_dec == 16'd0) begin
                        phase_next = PH_PAYLOAD;
                    end
                end else begin
                    has_data  = 1'b1;
                    data_kind = msd_pkg::KIND_PAYLOAD;
                end
                if (pend_next != msd_pkg::ST_OK) begin
                    has_data = 1'b0;
                end
                if (pkt_end) begin
                    res_valid = 1'b1;
                    r_last    = 1'b1;
                    if (pend_next != msd_pkg::ST_OK) begin
                        r_status = pend_next;
                    end else begin
                        phase_next = PH_HEADER;
                        if (has_data) begin
                            r_kind = data_kind;
                            r_data = b;
                        end
                    end
                end else if (endb) begin
                    res_valid = 1'b1;
                    r_last    = 1'b1;
                    r_status  = msd_pkg::ST_LENGTH;
                end else if (has_data) begin
                    res_valid = 1'b1;
                    r_kind    = data_kind;
                    r_data    = b;
                end
            end
            PH_DROP: begin
                if (endb) begin
                    phase_next = PH_HEADER;
                end
            end
            default: begin
                phase_next = PH_HEADER;
            end
        endcase

        // any error word leaves the packet: resync on the buffer end
        if (res_valid && r_status != msd_pkg::ST_OK) begin
            phase_next = endb ? PH_HEADER : PH_DROP;
        end
    end

    always_comb begin
        res_word.result_kind      = r_kind;
        res_word.data_byte        = r_data;
        res_word.packet_type      = type_next;
        res_word.qos_level        = qos_next;
        res_word.remaining_length = acc_next;
        res_word.last_of_packet   = r_last;
        res_word.status           = r_status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            acc_reg      <= 28'd0;
            lcount_reg   <= 2'd0;
            left_reg     <= 28'd0;
            topic_hi_reg <= 8'd0;
            tleft_reg    <= 16'd0;
            type_reg     <= 4'd0;
            qos_reg      <= 2'd0;
            pend_reg     <= msd_pkg::ST_OK;
        end else if (accept) begin
            phase_reg    <= phase_next;
            acc_reg      <= acc_next;
            lcount_reg   <= lcount_next;
            left_reg     <= left_next;
            topic_hi_reg <= topic_hi_next;
            tleft_reg    <= tleft_next;
            type_reg     <= type_next;
            qos_reg      <= qos_next;
            pend_reg     <= pend_next;
        end
    end

endmodule

// ----- hw/rtl/msd_fifo.sv -----
// Short result queue between the parser and the output stage.
module msd_fifo #(
    parameter int unsigned DEPTH = msd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  msd_pkg::out_word_t  push_word,
    input  logic                pop,
    output msd_pkg::out_word_t  pop_word,
    output msd_pkg::q_status_t  q_status
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    msd_pkg::out_word_t store_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == FULL_CNT);
    assign q_status.empty = (count_reg == '0);
    assign pop_word = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/msd_back.sv -----
// Back end: drains the queue into the registered result channel.
module msd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  msd_pkg::q_status_t q_status,
    input  msd_pkg::out_word_t q_word,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output msd_pkg::out_word_t m_data
);

    logic               m_valid_reg;
    msd_pkg::out_word_t m_data_reg;

    // refill whenever the output register is empty or being taken
    assign q_pop   = !q_status.empty && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (q_pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_data_reg <= q_word;
        end
    end

endmodule

// ----- hw/rtl/mqtt_stream_deframer.sv -----
// MQTT stream deframer top level: parser, result queue and output stage.
//
// Takes one received byte a cycle on s_ and splits back-to-back MQTT control
// packets; each byte gives at most one result word on m_ (topic byte, payload
// byte or a status-only word), the last word of a packet carrying the status.
// Sustained rate is one byte per cycle; a result word passes through the result
// queue and then the output register before it is on m_valid. The parser stalls
// only when the QUEUE_DEPTH-entry result queue is full, i.e. when the sink holds
// m_ready low. The length limit is written through cfg_valid/cfg_data (always
// ready) only while the block is idle: a user rule the block does not enforce.
module mqtt_stream_deframer #(
    parameter int unsigned QUEUE_DEPTH = msd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  msd_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output msd_pkg::out_word_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [27:0]        cfg_data
);

    logic [27:0]        max_len_reg;
    logic               accept;
    logic               res_valid;
    msd_pkg::out_word_t res_word;
    msd_pkg::out_word_t q_word;
    msd_pkg::q_status_t q_status;
    logic               q_pop;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_status.full;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= msd_pkg::MAX_LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_len_reg <= cfg_data;
        end
    end

    msd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_word   (s_data),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res_word  (res_word)
    );

    msd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && res_valid),
        .push_word (res_word),
        .pop       (q_pop),
        .pop_word  (q_word),
        .q_status  (q_status)
    );

    msd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_word   (q_word),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
